// ===== src/zbgp_pkg.sv =====
// ----------------------------------------------------------------------------
// zbgp_pkg
// Shared types and constants for the zero-byte group packer.
// ----------------------------------------------------------------------------
package zbgp_pkg;

	// Widths of the fixed fields.
	localparam int BYTE_W  = 8;
	localparam int MAP_W   = 8;
	localparam int COUNT_W = 4;
	localparam int POS_W   = 3;

	// Control part of one closed group, passed from the front to the back.
	typedef struct packed {
		logic [MAP_W-1:0]   tag;
		logic [COUNT_W-1:0] count;
		logic               has_fill;
		logic [COUNT_W-1:0] fill;
		logic               last;
	} zbgp_group_t;

endpackage

// ===== src/zbgp_front.sv =====
// ----------------------------------------------------------------------------
// zbgp_front
// Accepts message bytes, builds the presence map and the kept byte buffer,
// and hands a closed group to the group queue.
// ----------------------------------------------------------------------------
module zbgp_front
	import zbgp_pkg::*;
#(
	parameter int GROUP_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [BYTE_W-1:0]                   in_byte,
	input  logic                                in_last,
	input  logic                                q_full,
	output logic                                push,
	output zbgp_group_t                         push_group,
	output logic [GROUP_BYTES-1:0][BYTE_W-1:0]  push_bytes
);

	logic [POS_W-1:0]                  pos_q;
	logic [COUNT_W-1:0]                cnt_q;
	logic [MAP_W-1:0]                  map_q;
	logic [GROUP_BYTES-1:0][BYTE_W-1:0] kept_q;

	logic                               accept;
	logic                               nonzero;
	logic [COUNT_W-1:0]                 seen;
	logic                               close;
	logic [MAP_W-1:0]                   map_nx;
	logic [COUNT_W-1:0]                 cnt_nx;
	logic [GROUP_BYTES-1:0][BYTE_W-1:0] kept_nx;

	// The front only holds off while the queue has no room for a group.
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Merge the incoming byte into the open group.
	always_comb begin
		nonzero = (in_byte != '0);
		seen    = {1'b0, pos_q} + COUNT_W'(1);
		close   = in_last || (seen == COUNT_W'(GROUP_BYTES));
		map_nx  = map_q | (MAP_W'(nonzero) << pos_q);
		cnt_nx  = nonzero ? (cnt_q + COUNT_W'(1)) : cnt_q;
		kept_nx = kept_q;
		for (int i = 0; i < GROUP_BYTES; i++) begin
			if (nonzero && (cnt_q == COUNT_W'(i))) begin
				kept_nx[i] = in_byte;
			end
		end
	end

	// Describe the group that this byte closes.
	always_comb begin
		push                = accept && close;
		push_group.tag      = map_nx;
		push_group.count    = cnt_nx;
		push_group.has_fill = in_last && (seen != COUNT_W'(GROUP_BYTES));
		push_group.fill     = COUNT_W'(GROUP_BYTES) - seen;
		push_group.last     = in_last;
		push_bytes          = kept_nx;
	end

	// Group state: cleared when a group closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			map_q <= '0;
		end else if (accept) begin
			if (close) begin
				pos_q <= '0;
				cnt_q <= '0;
				map_q <= '0;
			end else begin
				pos_q <= seen[POS_W-1:0];
				cnt_q <= cnt_nx;
				map_q <= map_nx;
			end
		end
	end

	// Kept byte buffer.
	always_ff @(posedge clk) begin
		if (accept) begin
			kept_q <= kept_nx;
		end
	end

endmodule

// ===== src/zbgp_queue.sv =====
// ----------------------------------------------------------------------------
// zbgp_queue
// Two-entry queue of closed groups between the front and the back.
// ----------------------------------------------------------------------------
module zbgp_queue
	import zbgp_pkg::*;
#(
	parameter int GROUP_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  zbgp_group_t                        push_group,
	input  logic [GROUP_BYTES-1:0][BYTE_W-1:0] push_bytes,
	input  logic                               pop,
	output logic                               full,
	output logic                               head_valid,
	output zbgp_group_t                        head_group,
	output logic [GROUP_BYTES-1:0][BYTE_W-1:0] head_bytes
);

	zbgp_group_t                               group_q [2];
	logic [GROUP_BYTES-1:0][BYTE_W-1:0]        bytes_q [2];
	logic                                      wr_ptr_q;
	logic                                      rd_ptr_q;
	logic [1:0]                                count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_group = group_q[rd_ptr_q];
	assign head_bytes = bytes_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			group_q[wr_ptr_q] <= push_group;
			bytes_q[wr_ptr_q] <= push_bytes;
		end
	end

endmodule

// ===== src/zbgp_back.sv =====
// ----------------------------------------------------------------------------
// zbgp_back
// Walks the group at the head of the queue and sends the tag, the kept
// bytes and the fill count through a registered output stage.
// ----------------------------------------------------------------------------
module zbgp_back
	import zbgp_pkg::*;
#(
	parameter int GROUP_BYTES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  zbgp_group_t                        head_group,
	input  logic [GROUP_BYTES-1:0][BYTE_W-1:0] head_bytes,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [BYTE_W-1:0]                  out_byte,
	output logic                               run_last,
	output logic                               message_end
);

	logic [COUNT_W-1:0] idx_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               run_last_q;
	logic               message_end_q;

	logic               take;
	logic               final_byte;
	logic [COUNT_W-1:0] last_idx;
	logic [BYTE_W-1:0]  sel_byte;

	// A new byte enters the output stage when it is empty or being drained.
	assign take = head_valid && (!out_valid_q || !out_stall);
	assign pop  = take && final_byte;

	// Pick the byte at the current position of the group.
	always_comb begin
		last_idx   = head_group.count + COUNT_W'(head_group.has_fill);
		final_byte = (idx_q == last_idx);
		sel_byte   = BYTE_W'(head_group.fill);
		if (idx_q == '0) begin
			sel_byte = head_group.tag;
		end else begin
			for (int i = 0; i < GROUP_BYTES; i++) begin
				if ((idx_q == COUNT_W'(i + 1)) && (idx_q <= head_group.count)) begin
					sel_byte = head_bytes[i];
				end
			end
		end
	end

	// Position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= final_byte ? '0 : (idx_q + COUNT_W'(1));
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q    <= sel_byte;
			run_last_q    <= final_byte;
			message_end_q <= final_byte && head_group.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign message_end = message_end_q;

endmodule

// ===== src/zero_byte_group_packer.sv =====
// The packer takes one message byte per cycle and cuts the message into groups
// of GROUP_BYTES bytes. A closed group leaves as a tag byte (bit i set for a
// nonzero byte i), then its nonzero bytes, then a fill count if the message
// ended in a partial group. Input is taken every cycle while the two-entry
// group queue has room; the output port sends one byte per cycle unless
// stalled, so a group is 1 + kept bytes (+1 fill) output bytes, up to
// GROUP_BYTES + 1, and the output port sets the sustained rate. A full group
// of nonzero bytes gives (GROUP_BYTES + 1) / GROUP_BYTES output bytes per
// input byte; the worst case is three: with GROUP_BYTES above one, a one-byte
// message holding a nonzero byte sends the tag, the byte and the fill count.
// ----------------------------------------------------------------------------
// zero_byte_group_packer
// Top level: front, group queue and back of the zero-byte group packer.
// ----------------------------------------------------------------------------
module zero_byte_group_packer
	import zbgp_pkg::*;
#(
	parameter int GROUP_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              run_last,
	output logic              message_end
);

	logic                               q_full;
	logic                               push;
	zbgp_group_t                        push_group;
	logic [GROUP_BYTES-1:0][BYTE_W-1:0] push_bytes;
	logic                               pop;
	logic                               head_valid;
	zbgp_group_t                        head_group;
	logic [GROUP_BYTES-1:0][BYTE_W-1:0] head_bytes;

	// Front: builds groups from incoming transfers.
	zbgp_front #(.GROUP_BYTES(GROUP_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.q_full     (q_full),
		.push       (push),
		.push_group (push_group),
		.push_bytes (push_bytes)
	);

	// Queue of closed groups.
	zbgp_queue #(.GROUP_BYTES(GROUP_BYTES)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.push_bytes (push_bytes),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_group (head_group),
		.head_bytes (head_bytes)
	);

	// Back: serializes groups onto the output channel.
	zbgp_back #(.GROUP_BYTES(GROUP_BYTES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_group  (head_group),
		.head_bytes  (head_bytes),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule

// ===== src/zbgp_checker.sv =====
// ----------------------------------------------------------------------------
// zbgp_checker
// Port-level checks of the zero-byte group packer, bound to the top level.
// ----------------------------------------------------------------------------
module zbgp_checker
	import zbgp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [BYTE_W-1:0] in_byte,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_stall,
	input logic [BYTE_W-1:0] out_byte,
	input logic              run_last,
	input logic              message_end
);

	// The end of a message always ends the run of its closing transfer.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> run_last)
		else $error("message_end without run_last");

	// A stalled output transfer holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
			$stable(run_last) && $stable(message_end))
		else $error("stalled output changed");

	// Nothing is offered and nothing held off while in reset.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("activity during reset");

	// The input only stalls after a transfer filled the group queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall without a preceding transfer");

endmodule

bind zero_byte_group_packer zbgp_checker u_zbgp_checker (.*);

// ===== tb/zero_byte_group_packer_tb.sv =====
// ----------------------------------------------------------------------------
// zero_byte_group_packer_tb
// Self-checking bench for the zero-byte group packer. A directed set of short
// messages covers all-zero and all-nonzero groups, single-byte messages and
// exact multiples of the group size. Random messages with random zero density
// follow. Both sides idle and stall at random. A packing model predicts every
// output byte, and each output transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module zero_byte_group_packer_tb
	import zbgp_pkg::*;
;

	localparam int GROUP_BYTES  = 8;
	localparam int RANDOM_BYTES = 185;
	localparam int TAIL_CYCLES  = 2 * GROUP_BYTES + 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_PRINTS   = 40;

	// One output byte as the packer should send it.
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              run_last;
		logic              message_end;
	} packed_beat_t;

	// Packing model: rebuilds each group and queues the bytes it must produce.
	class packed_stream_model;
		logic [BYTE_W-1:0]  kept [GROUP_BYTES];
		logic [COUNT_W-1:0] kept_count;
		logic [POS_W-1:0]   position;
		logic [MAP_W-1:0]   tag;
		packed_beat_t       packed_bytes_due [$];
		int unsigned        errors;

		function new();
			kept_count = '0;
			position   = '0;
			tag        = '0;
			errors     = 0;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function int due_count();
			return packed_bytes_due.size();
		endfunction

		// Note one accepted input transfer and queue whatever it releases.
		function void take_raw_byte(logic [BYTE_W-1:0] raw, logic last);
			packed_beat_t beats [GROUP_BYTES + 1];
			int           n;
			int           seen;
			if (raw != '0) begin
				tag[position]    = 1'b1;
				kept[kept_count] = raw;
				kept_count       = kept_count + 1'b1;
			end
			seen = int'(position) + 1;
			if (seen < GROUP_BYTES && !last) begin
				position = POS_W'(seen);
				return;
			end
			// The group closes: tag, kept bytes, then fill count if partial.
			n = 0;
			beats[n] = '{tag, 1'b0, 1'b0};
			n++;
			for (int i = 0; i < int'(kept_count); i++) begin
				beats[n] = '{kept[i], 1'b0, 1'b0};
				n++;
			end
			if (last && seen < GROUP_BYTES) begin
				beats[n] = '{BYTE_W'(GROUP_BYTES - seen), 1'b0, 1'b0};
				n++;
			end
			beats[n-1].run_last    = 1'b1;
			beats[n-1].message_end = last;
			for (int i = 0; i < n; i++)
				packed_bytes_due.push_back(beats[i]);
			kept_count = '0;
			position   = '0;
			tag        = '0;
		endfunction

		// Compare one output transfer with the oldest queued byte.
		task check_packed_byte(logic [BYTE_W-1:0] value, logic run_last, logic message_end);
			packed_beat_t want;
			if (packed_bytes_due.size() == 0) begin
				report($sformatf("unexpected output byte %02h", value));
				return;
			end
			want = packed_bytes_due.pop_front();
			if (value !== want.value)
				report($sformatf("out_byte %02h, want %02h", value, want.value));
			if (run_last !== want.run_last)
				report($sformatf("run_last %b, want %b (byte %02h)", run_last, want.run_last,
					want.value));
			if (message_end !== want.message_end)
				report($sformatf("message_end %b, want %b (byte %02h)", message_end,
					want.message_end, want.value));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;
	logic              out_valid;
	logic              out_stall;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              message_end;

	packed_stream_model model = new();

	bit          tx_steady;
	bit          rx_steady;
	int          rx_hold;
	int unsigned cycle_count;
	int          random_sent;
	bit          drained;

	zero_byte_group_packer #(
		.GROUP_BYTES(GROUP_BYTES)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.message_end(message_end)
	);

	// Clock with a period of 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Timeout on a cycle count.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Output side: check each transfer, then draw a stall for the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				model.check_packed_byte(out_byte, run_last, message_end);
				rx_hold = rx_steady ? 0 : $urandom_range(0, 5);
			end else if (rx_hold > 0) begin
				rx_hold--;
			end
			out_stall <= (rx_hold > 0);
		end
	end

	// Offer one byte after a random gap and hold it until the transfer.
	task send_byte(logic [BYTE_W-1:0] raw, logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= raw;
		in_last  <= last;
		do @(posedge clk); while (in_stall);
		model.take_raw_byte(raw, last);
	endtask

	// Hold off the input until every queued output byte has come out.
	task drain_outputs();
		in_valid <= 1'b0;
		while (model.due_count() != 0) @(posedge clk);
	endtask

	// One random message; zero_pct sets how many of its bytes are zero.
	task send_random_message(int len, int zero_pct);
		logic [BYTE_W-1:0] raw;
		int                pick;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 7);
			if ($urandom_range(0, 99) < zero_pct)
				raw = '0;
			else if (pick == 0)
				raw = 8'hff;
			else if (pick == 1)
				raw = 8'h01;
			else
				raw = BYTE_W'($urandom_range(1, 255));
			send_byte(raw, i == len - 1);
		end
	endtask

	initial begin
		int len;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		in_last   <= 1'b0;
		out_stall <= 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-byte messages: a zero byte and a full-scale byte.
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// Eight nonzero bytes ending the message: nine outputs and no fill.
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'hfe, 1'b0);
		send_byte(8'h02, 1'b1);
		// A full group of zeros that does not end the message.
		for (int i = 0; i < GROUP_BYTES; i++)
			send_byte(8'h00, 1'b0);
		// The same message then ends in a partial mixed group.
		send_byte(8'h00, 1'b0);
		send_byte(8'hc3, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h00, 1'b1);

		// Random messages, with idling switched off now and then.
		random_sent = 0;
		drained     = 1'b0;
		while (random_sent < RANDOM_BYTES) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			send_random_message(len, $urandom_range(0, 100));
			random_sent += len;
			if (!drained && random_sent >= RANDOM_BYTES / 2) begin
				drain_outputs();
				drained = 1'b1;
			end
		end
		in_valid <= 1'b0;
		rx_steady = 1'b0;

		// Let the last groups drain, then watch for stray output.
		while (model.due_count() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (model.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/zbgp_pkg.sv
src/zbgp_front.sv
src/zbgp_queue.sv
src/zbgp_back.sv
src/zero_byte_group_packer.sv
src/zbgp_checker.sv
tb/zero_byte_group_packer_tb.sv
